[sv/hcbp_pkg.sv]
// ----------------------------------------------------------------------------
// hcbp_pkg
// Shared types, widths and parameter defaults of the Huffman code bit packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package hcbp_pkg;

  // Fixed field widths
  localparam int SYM_W   = 8;
  localparam int CODE_W  = 16;
  localparam int LEN_W   = 5;
  localparam int BYTE_W  = 8;
  localparam int TOTAL_W = 32;
  localparam int PEND_W  = 7;
  localparam int CNT_W   = 3;
  localparam int ACC_W   = PEND_W + CODE_W;

  // Parameter defaults
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int SYMBOL_COUNT_DEF = 256;

  // Item kinds carried in tuser; the fourth code is ignored
  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_ENCODE = 2'd1,
    ACT_FLUSH  = 2'd2
  } action_e;

  // One output beat
  typedef struct packed {
    logic [BYTE_W-1:0]  out_byte;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } out_item_t;

  // Stage-one control handed to the packer
  typedef struct packed {
    logic       valid;
    logic [1:0] action;
    logic       fire;
  } pk_ctrl_t;

  // Packer results: up to two beats
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } pk_res_t;

endpackage

`default_nettype wire

[sv/hcbp_code_mem.sv]
// ----------------------------------------------------------------------------
// hcbp_code_mem
// Code and length store: one synchronous RAM with a registered read port,
// plus per-entry valid bits so unwritten entries read as length zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcbp_code_mem #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        wr_en_i,
  input  wire logic                        rd_en_i,
  input  wire logic [hcbp_pkg::SYM_W-1:0]  sym_i,
  input  wire logic [hcbp_pkg::CODE_W-1:0] wr_code_i,
  input  wire logic [hcbp_pkg::LEN_W-1:0]  wr_len_i,
  output logic      [hcbp_pkg::CODE_W-1:0] rd_code_o,
  output logic      [hcbp_pkg::LEN_W-1:0]  rd_len_o
);
  import hcbp_pkg::*;

  localparam int AW = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int CAP_INT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam logic [LEN_W-1:0] LenCap = LEN_W'(CAP_INT);
  localparam int ENT_W = CODE_W + LEN_W;

  logic [ENT_W-1:0]        mem_q [SYMBOL_COUNT];
  logic [SYMBOL_COUNT-1:0] vld_q;
  logic [ENT_W-1:0]        rd_q;
  logic                    hit_q;
  logic                    in_range;
  logic [AW-1:0]           idx;
  logic [LEN_W-1:0]        len_clamped;

  assign in_range    = (32'(sym_i) < 32'(SYMBOL_COUNT));
  assign idx         = sym_i[AW-1:0];
  assign len_clamped = (wr_len_i > LenCap) ? LenCap : wr_len_i;

  // RAM write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en_i && in_range) begin
      mem_q[idx] <= {wr_code_i, len_clamped};
    end
    if (rd_en_i) begin
      rd_q <= mem_q[idx];
    end
  end

  // Valid bits and registered hit flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      hit_q <= 1'b0;
    end else begin
      if (wr_en_i && in_range) begin
        vld_q[idx] <= 1'b1;
      end
      if (rd_en_i) begin
        hit_q <= in_range && vld_q[idx];
      end
    end
  end

  assign rd_code_o = rd_q[ENT_W-1:LEN_W];
  assign rd_len_o  = hit_q ? rd_q[LEN_W-1:0] : '0;

endmodule

`default_nettype wire

[sv/hcbp_packer.sv]
// ----------------------------------------------------------------------------
// hcbp_packer
// MSB-first bit packer: merges a looked-up code with the waiting bits,
// cuts out up to two whole bytes and keeps the saturating bit total.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcbp_packer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire hcbp_pkg::pk_ctrl_t          ctrl_i,
  input  wire logic [hcbp_pkg::CODE_W-1:0] code_i,
  input  wire logic [hcbp_pkg::LEN_W-1:0]  len_i,
  output hcbp_pkg::pk_res_t                res_o
);
  import hcbp_pkg::*;

  logic [PEND_W-1:0]  pend_q, pend_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [TOTAL_W-1:0] total_q, total_d;

  logic [CODE_W:0]    code_mask;
  logic [CODE_W-1:0]  code_m;
  logic [ACC_W-1:0]   acc, sh0, sh1;
  logic [LEN_W-1:0]   cnt_sum;
  logic [CNT_W-1:0]   cnt_new;
  logic [PEND_W:0]    pmask;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_enc;
  logic [14:0]        fsh;

  // Merge code into the waiting bits
  always_comb begin
    code_mask = (17'(1) << len_i) - 17'(1);
    code_m    = code_i & code_mask[CODE_W-1:0];
    acc       = (ACC_W'(pend_q) << len_i) | ACC_W'(code_m);
    cnt_sum   = LEN_W'(cnt_q) + len_i;
    cnt_new   = cnt_sum[CNT_W-1:0];
    pmask     = (8'd1 << cnt_new) - 8'd1;
    sh0       = acc >> (cnt_sum - 5'd8);
    sh1       = acc >> (cnt_sum - 5'd16);
    sum       = {1'b0, total_q} + (TOTAL_W+1)'(len_i);
    total_enc = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    fsh       = 15'(pend_q) << (4'd8 - {1'b0, cnt_q});
  end

  // Result beats and next state
  always_comb begin
    res_o   = '0;
    pend_d  = pend_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    if (ctrl_i.valid) begin
      case (ctrl_i.action)
        ACT_ENCODE: begin
          if (len_i != '0) begin
            res_o.n            = cnt_sum[4:3];
            res_o.r0.out_byte  = sh0[BYTE_W-1:0];
            res_o.r0.last      = (cnt_sum[4:3] == 2'd1);
            res_o.r0.total     = total_enc;
            res_o.r1.out_byte  = sh1[BYTE_W-1:0];
            res_o.r1.last      = 1'b1;
            res_o.r1.total     = total_enc;
            pend_d             = acc[PEND_W-1:0] & pmask[PEND_W-1:0];
            cnt_d              = cnt_new;
            total_d            = total_enc;
          end
        end
        ACT_FLUSH: begin
          res_o.n           = 2'd1;
          res_o.r0.out_byte = fsh[BYTE_W-1:0];
          res_o.r0.last     = 1'b1;
          res_o.r0.total    = total_q;
          pend_d            = '0;
          cnt_d             = '0;
          total_d           = '0;
        end
        default: begin
          res_o.n = 2'd0;
        end
      endcase
    end
  end

  // Packer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      cnt_q   <= '0;
      total_q <= '0;
    end else if (ctrl_i.fire) begin
      pend_q  <= pend_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
    end
  end

endmodule

`default_nettype wire

[sv/hcbp_out_queue.sv]
// ----------------------------------------------------------------------------
// hcbp_out_queue
// Two-slot output queue: takes up to two beats at once and presents one
// beat per cycle from its head slot while the reader takes them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module hcbp_out_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [1:0]          push_n_i,
  input  wire hcbp_pkg::out_item_t push0_i,
  input  wire hcbp_pkg::out_item_t push1_i,
  input  wire logic                pop_i,
  output hcbp_pkg::out_item_t      head_o,
  output logic [1:0]               cnt_o
);
  import hcbp_pkg::*;

  out_item_t  s0_q, s0_d, s1_q, s1_d;
  logic [1:0] cnt_q, cnt_d, cnt_pop;

  // Shift on pop, then append behind what is left
  always_comb begin
    cnt_pop = cnt_q - {1'b0, pop_i};
    s0_d    = pop_i ? s1_q : s0_q;
    s1_d    = s1_q;
    case (cnt_pop)
      2'd0: begin
        s0_d = push0_i;
        s1_d = push1_i;
      end
      2'd1: begin
        s1_d = push0_i;
      end
      default: begin
        s1_d = s1_q;
      end
    endcase
    cnt_d = cnt_pop + push_n_i;
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  assign head_o = s0_q;
  assign cnt_o  = cnt_q;

endmodule

`default_nettype wire

[sv/huffman_code_bit_packer_core.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core
// Table-driven Huffman encoder with an MSB-first byte packer.
// ----------------------------------------------------------------------------
// Input beats carry the kind in tuser (load, encode, flush). A load writes a
// symbol's code and length into the code RAM; an encode reads it back from
// the registered read port and appends the code bits to the packer; a flush
// emits the partial byte padded with zeros and the bit total, then clears
// both. Beats flow through two stages (RAM read, then pack) into a two-slot
// output queue. A new beat is taken every cycle while each beat yields at
// most one output byte and m_axis_tready stays high; encodes that complete two
// bytes can hold the input back, set by the one-byte-per-cycle output port. A
// load followed directly by an encode of the same symbol sees the new entry. No
// clearing pass after reset: the length store uses one valid bit per entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module huffman_code_bit_packer_core #(
  parameter int MAX_CODE_LEN = hcbp_pkg::MAX_CODE_LEN_DEF,
  parameter int SYMBOL_COUNT = hcbp_pkg::SYMBOL_COUNT_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // symbol[7:0], code_bits[23:8], code_len[28:24]
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,  // out_byte[7:0], total_bits[39:8]
  output logic             m_axis_tlast   // last_of_run
);
  import hcbp_pkg::*;

  logic              accept, fire, pop;
  logic              s1_valid_q;
  logic [1:0]        s1_action_q;
  logic [CODE_W-1:0] rd_code;
  logic [LEN_W-1:0]  rd_len;
  logic [1:0]        q_cnt;
  logic [2:0]        q_need;
  pk_ctrl_t          pk_ctrl;
  pk_res_t           pk_res;
  out_item_t         head;

  // Handshakes
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign pop           = m_axis_tvalid && m_axis_tready;
  assign q_need        = 3'(q_cnt) - 3'(pop) + 3'(pk_res.n);
  assign fire          = s1_valid_q && (q_need <= 3'd2);
  assign s_axis_tready = !s1_valid_q || fire;

  // Code store
  hcbp_code_mem #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .SYMBOL_COUNT (SYMBOL_COUNT)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && (s_axis_tuser == ACT_LOAD)),
    .rd_en_i   (accept),
    .sym_i     (s_axis_tdata[7:0]),
    .wr_code_i (s_axis_tdata[23:8]),
    .wr_len_i  (s_axis_tdata[28:24]),
    .rd_code_o (rd_code),
    .rd_len_o  (rd_len)
  );

  // Pack stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_action_q <= '0;
    end else if (s_axis_tready) begin
      s1_valid_q  <= s_axis_tvalid;
      s1_action_q <= s_axis_tuser;
    end
  end

  assign pk_ctrl.valid  = s1_valid_q;
  assign pk_ctrl.action = s1_action_q;
  assign pk_ctrl.fire   = fire;

  hcbp_packer u_packer (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (pk_ctrl),
    .code_i (rd_code),
    .len_i  (rd_len),
    .res_o  (pk_res)
  );

  hcbp_out_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (fire ? pk_res.n : 2'd0),
    .push0_i  (pk_res.r0),
    .push1_i  (pk_res.r1),
    .pop_i    (pop),
    .head_o   (head),
    .cnt_o    (q_cnt)
  );

  // Output beat
  assign m_axis_tvalid = (q_cnt != 2'd0);
  assign m_axis_tdata  = {head.total, head.out_byte};
  assign m_axis_tlast  = head.last;

`ifndef ASSERT_OFF
  // Queue never overfills
  a_queue_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt != 2'd3)
    else $error("output queue overfilled");

  // A stalled pack stage keeps its item
  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !fire |=> s1_valid_q && $stable(s1_action_q))
    else $error("pack stage item lost while stalled");

  // A flush always yields exactly one beat
  a_flush_one : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && (s1_action_q == ACT_FLUSH) |-> pk_res.n == 2'd1)
    else $error("flush did not produce one beat");
`endif

endmodule

`default_nettype wire

[tb/hcbp_stream_checker.sv]
// ----------------------------------------------------------------------------
// hcbp_stream_checker
// Watches both stream ports of the code bit packer, predicts every output
// beat from the accepted input beats and compares them in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hcbp_stream_checker #(
  parameter int MAX_LEN = hcbp_pkg::MAX_CODE_LEN_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // symbol[7:0], code_bits[23:8], code_len[28:24]
  input  wire logic [1:0]  s_axis_tuser,  // action[1:0]
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [39:0] m_axis_tdata,  // out_byte[7:0], total_bits[39:8]
  input  wire logic        m_axis_tlast,  // last_of_run
  output int               fail_count_o,
  output int               pending_o
);

  import hcbp_pkg::*;

  // Own copy of the code tables and the packer
  logic [CODE_W-1:0]  code_tab [256];
  logic [LEN_W-1:0]   len_tab  [256];
  logic [PEND_W-1:0]  held_bits;
  logic [CNT_W-1:0]   held_cnt;
  logic [TOTAL_W-1:0] bits_so_far;

  out_item_t byte_queue[$];

  function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
    int cap;
    cap = (MAX_LEN > CODE_W) ? CODE_W : MAX_LEN;
    return (int'(len) > cap) ? LEN_W'(cap) : len;
  endfunction

  // Append one symbol's code to the packer and queue any completed bytes
  task automatic pack_symbol(input logic [SYM_W-1:0] sym);
    int                 len;
    int                 cnt;
    logic [ACC_W-1:0]   acc;
    logic [31:0]        code;
    out_item_t          item;
    len = int'(len_tab[sym]);
    if (len == 0) return;
    code = 32'(code_tab[sym]) & ((32'd1 << len) - 32'd1);
    if (bits_so_far > 32'hFFFF_FFFF - 32'(len)) bits_so_far = 32'hFFFF_FFFF;
    else bits_so_far = bits_so_far + 32'(len);
    acc = (ACC_W'(held_bits) << len) | ACC_W'(code);
    cnt = int'(held_cnt) + len;
    while (cnt >= 8) begin
      item.out_byte = BYTE_W'(acc >> (cnt - 8));
      cnt           = cnt - 8;
      item.last     = (cnt < 8);
      item.total    = bits_so_far;
      byte_queue    = {byte_queue, item};
    end
    held_cnt  = CNT_W'(cnt);
    held_bits = PEND_W'(acc & ((ACC_W'(1) << cnt) - ACC_W'(1)));
  endtask

  // Pad the partial byte, report the total and clear the packer
  task automatic flush_packer();
    out_item_t item;
    item.out_byte = (held_cnt == 0) ? '0 : BYTE_W'({1'b0, held_bits} << (8 - held_cnt));
    item.last     = 1'b1;
    item.total    = bits_so_far;
    byte_queue    = {byte_queue, item};
    held_bits   = '0;
    held_cnt    = '0;
    bits_so_far = '0;
  endtask

  task automatic check_beat();
    out_item_t want;
    logic      bad;
    if (byte_queue.size() == 0) begin
      fail_count_o++;
      $display("%0t: unexpected output beat: expected none, actual byte %02h last %0d total %0d",
               $realtime, m_axis_tdata[7:0], m_axis_tlast, m_axis_tdata[39:8]);
      return;
    end
    want = byte_queue.pop_front();
    bad  = 1'b0;
    if (m_axis_tdata[7:0] !== want.out_byte) begin
      bad = 1'b1;
      $display("%0t: out_byte mismatch: expected %02h actual %02h",
               $realtime, want.out_byte, m_axis_tdata[7:0]);
    end
    if (m_axis_tlast !== want.last) begin
      bad = 1'b1;
      $display("%0t: last_of_run mismatch: expected %0d actual %0d",
               $realtime, want.last, m_axis_tlast);
    end
    if (m_axis_tdata[39:8] !== want.total) begin
      bad = 1'b1;
      $display("%0t: total_bits mismatch: expected %0d actual %0d",
               $realtime, want.total, m_axis_tdata[39:8]);
    end
    if (bad) fail_count_o++;
  endtask

  // Predict on every input beat, compare on every output beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 256; i++) len_tab[i] = '0;
      held_bits    = '0;
      held_cnt     = '0;
      bits_so_far  = '0;
      fail_count_o = 0;
      byte_queue.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        case (action_e'(s_axis_tuser))
          ACT_LOAD: begin
            code_tab[s_axis_tdata[7:0]] = s_axis_tdata[23:8];
            len_tab[s_axis_tdata[7:0]]  = clamp_len(s_axis_tdata[28:24]);
          end
          ACT_ENCODE: pack_symbol(s_axis_tdata[7:0]);
          ACT_FLUSH:  flush_packer();
          default: ;  // reserved kind is dropped
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) check_beat();
    end
    pending_o = byte_queue.size();
  end

endmodule

[tb/huffman_code_bit_packer_core_tb.sv]
// ----------------------------------------------------------------------------
// huffman_code_bit_packer_core_tb
// Drives load, encode, flush and reserved beats with random gaps and output
// back-pressure; a separate checker predicts and compares the bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module huffman_code_bit_packer_core_tb;

  import hcbp_pkg::*;

  localparam logic [1:0] ACT_RESERVED = 2'd3;
  localparam int         RAND_ITEMS   = 1700;
  localparam int         CYCLE_LIMIT  = 400000;
  localparam int         DRAIN_CYCLES = 20;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata  = '0;  // symbol[7:0], code_bits[23:8], code_len[28:24]
  logic [1:0]  s_axis_tuser  = '0;  // action[1:0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;        // out_byte[7:0], total_bits[39:8]
  logic        m_axis_tlast;        // last_of_run

  int fail_count;
  int pending;
  int cycles = 0;
  int stall_left = 0;
  bit calm = 1'b0;                  // no gaps on either side while set

  // Symbols whose table entry has been written at least once
  bit known[256];
  int known_syms[$];

  huffman_code_bit_packer_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  hcbp_stream_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Output back-pressure: a random stall, possibly none, after each beat taken
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (!m_axis_tready) begin
      if (stall_left <= 1) m_axis_tready <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (m_axis_tvalid) begin
      int w;
      w = calm ? 0 : $urandom_range(0, 11);
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= w;
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // One input beat, preceded by a random gap
  task automatic send_beat(input logic [1:0] act, input logic [SYM_W-1:0] sym,
                           input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tdata  <= {3'b000, len, code, sym};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (act == ACT_LOAD && !known[sym]) begin
      known[sym] = 1'b1;
      known_syms = {known_syms, int'(sym)};
    end
  endtask

  function automatic logic [SYM_W-1:0] any_known();
    return SYM_W'(known_syms[$urandom_range(0, known_syms.size() - 1)]);
  endfunction

  function automatic logic [LEN_W-1:0] draw_len();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return LEN_W'($urandom_range(17, 31));
    return LEN_W'($urandom_range(1, 16));
  endfunction

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Table set-up: full-width, over-long, zero and short codes
    send_beat(ACT_LOAD, 8'h00, 16'hFFFF, 5'd16);
    send_beat(ACT_FLUSH, 8'h00, '0, '0);            // flush with nothing pending
    send_beat(ACT_LOAD, 8'hFF, 16'h0000, 5'd31);    // clamps to 16
    send_beat(ACT_LOAD, 8'hA5, 16'hAAAA, 5'd0);     // symbol with no code
    send_beat(ACT_LOAD, 8'h5A, 16'h5555, 5'd1);
    send_beat(ACT_LOAD, 8'h3C, 16'h0003, 5'd7);
    send_beat(ACT_LOAD, 8'h11, 16'h1234, 5'd17);

    // Encodes across byte boundaries, zero length, reserved kind
    send_beat(ACT_ENCODE, 8'h00, '0, '0);           // two bytes at once
    send_beat(ACT_ENCODE, 8'h5A, '0, '0);
    send_beat(ACT_ENCODE, 8'h3C, '0, '0);           // completes exactly one byte
    send_beat(ACT_ENCODE, 8'hA5, '0, '0);           // nothing appended
    send_beat(ACT_ENCODE, 8'h5A, '0, '0);           // bit waits in the packer
    send_beat(ACT_FLUSH, 8'h5A, '0, '0);
    send_beat(ACT_RESERVED, 8'hFF, 16'hFFFF, 5'd31);
    send_beat(ACT_ENCODE, 8'hFF, '0, '0);
    send_beat(ACT_ENCODE, 8'h3C, '0, '0);           // seven bits waiting
    send_beat(ACT_ENCODE, 8'h00, '0, '0);           // 23 bits: two bytes, seven left
    send_beat(ACT_FLUSH, 8'h00, '0, '0);
    send_beat(ACT_LOAD, 8'h77, 16'h00FF, 5'd9);     // load then encode the same symbol
    send_beat(ACT_ENCODE, 8'h77, '0, '0);
    send_beat(ACT_ENCODE, 8'h11, '0, '0);
    send_beat(ACT_FLUSH, 8'h11, '0, '0);

    // Random traffic: mostly encodes of known symbols, some table rewrites, flushes and reserved beats
    for (int i = 0; i < RAND_ITEMS; i++) begin
      int r;
      calm = ((i / 120) % 3) == 1;
      r = $urandom_range(0, 99);
      if (i < 48 || r < 12)
        send_beat(ACT_LOAD, SYM_W'($urandom_range(0, 255)),
                  CODE_W'($urandom_range(0, 65535)), draw_len());
      else if (r < 82)
        send_beat(ACT_ENCODE, any_known(), CODE_W'($urandom_range(0, 65535)),
                  LEN_W'($urandom_range(0, 31)));
      else if (r < 93)
        send_beat(ACT_FLUSH, any_known(), CODE_W'($urandom_range(0, 65535)),
                  LEN_W'($urandom_range(0, 31)));
      else
        send_beat(ACT_RESERVED, any_known(), CODE_W'($urandom_range(0, 65535)),
                  LEN_W'($urandom_range(0, 31)));
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    @(posedge clk_i);

    // Drain, then give the pipeline time to show any stray beat
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
